// ===== src/vtkd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtkd_pkg
// Shared types and constants for the VT100 key-sequence decoder.
// ----------------------------------------------------------------------------
package vtkd_pkg;

    localparam int PARAM_COUNT = 2;
    localparam int PARAM_BITS  = 16;
    localparam int INDEX_BITS  = 2;

    typedef logic [PARAM_BITS-1:0] param_t;
    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [7:0]            byte_t;

    localparam param_t PARAM_MAX = {PARAM_BITS{1'b1}};

    // Character codes that steer the decoder.
    localparam byte_t CH_ESC    = 8'd27;
    localparam byte_t CH_LBRACK = 8'h5B;
    localparam byte_t CH_UPPER_O = 8'h4F;
    localparam byte_t CH_UPPER_F = 8'h46;
    localparam byte_t CH_UPPER_H = 8'h48;
    localparam byte_t CH_UPPER_A = 8'h41;
    localparam byte_t CH_UPPER_B = 8'h42;
    localparam byte_t CH_UPPER_C = 8'h43;
    localparam byte_t CH_UPPER_D = 8'h44;
    localparam byte_t CH_UPPER_R = 8'h52;
    localparam byte_t CH_LOWER_C = 8'h63;
    localparam byte_t CH_TILDE  = 8'h7E;
    localparam byte_t CH_SEMI   = 8'h3B;
    localparam byte_t CH_QUERY  = 8'h3F;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        MODE_RAW   = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_ESC_O = 4'b0100,
        MODE_CSI   = 4'b1000
    } mode_t;

    typedef enum logic [3:0] {
        KEY_CHAR          = 4'd0,
        KEY_UP            = 4'd1,
        KEY_DOWN          = 4'd2,
        KEY_RIGHT         = 4'd3,
        KEY_LEFT          = 4'd4,
        KEY_HOME          = 4'd5,
        KEY_END           = 4'd6,
        KEY_INSERT        = 4'd7,
        KEY_DELETE        = 4'd8,
        KEY_PGUP          = 4'd9,
        KEY_PGDN          = 4'd10,
        KEY_CURSOR_REPORT = 4'd11,
        KEY_TERM_TYPE     = 4'd12
    } key_kind_t;

    typedef struct packed {
        key_kind_t key_kind;
        byte_t     char_value;
        logic      ctrl_flag;
        param_t    first_param;
        param_t    second_param;
    } result_t;

endpackage

// ===== src/vtkd_decode.sv =====
// ----------------------------------------------------------------------------
// vtkd_decode
// Escape-sequence state and the single-pass decode of one received byte.
// ----------------------------------------------------------------------------
module vtkd_decode
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  vtkd_pkg::byte_t         rx_byte,
    output logic                    result_valid,
    output vtkd_pkg::result_t       result
);

    localparam int WIDE_BITS = vtkd_pkg::PARAM_BITS + 4;
    typedef logic [WIDE_BITS-1:0] wide_t;

    vtkd_pkg::mode_t  mode_reg, mode_next;
    vtkd_pkg::index_t index_reg, index_next;
    vtkd_pkg::param_t param_reg [vtkd_pkg::PARAM_COUNT];
    vtkd_pkg::param_t param_next [vtkd_pkg::PARAM_COUNT];

    logic             is_digit;
    logic             index_open;
    vtkd_pkg::param_t cur_param;
    wide_t            cur_wide;
    wide_t            scaled;
    vtkd_pkg::param_t digit_result;

    assign is_digit   = (rx_byte >= vtkd_pkg::CH_ZERO) && (rx_byte <= vtkd_pkg::CH_NINE);
    assign index_open = (index_reg < vtkd_pkg::INDEX_BITS'(vtkd_pkg::PARAM_COUNT));
    assign cur_param  = param_reg[index_reg[0]];
    assign cur_wide   = WIDE_BITS'(cur_param);
    // Times ten as two shifts and an add; the low nibble of an ASCII digit is its value.
    assign scaled     = (cur_wide << 3) + (cur_wide << 1) + WIDE_BITS'(rx_byte[3:0]);
    assign digit_result = (scaled > WIDE_BITS'(vtkd_pkg::PARAM_MAX))
                        ? vtkd_pkg::PARAM_MAX
                        : scaled[vtkd_pkg::PARAM_BITS-1:0];

    always_comb
    begin
        mode_next     = mode_reg;
        index_next    = index_reg;
        param_next[0] = param_reg[0];
        param_next[1] = param_reg[1];
        result_valid  = 1'b0;
        result        = '0;

        unique case (mode_reg)
            vtkd_pkg::MODE_RAW:
            begin
                if (rx_byte == vtkd_pkg::CH_ESC)
                begin
                    mode_next = vtkd_pkg::MODE_ESC;
                end
                else
                begin
                    result_valid      = 1'b1;
                    result.key_kind   = vtkd_pkg::KEY_CHAR;
                    result.char_value = rx_byte;
                end
            end
            vtkd_pkg::MODE_ESC:
            begin
                if (rx_byte == vtkd_pkg::CH_LBRACK)
                begin
                    mode_next     = vtkd_pkg::MODE_CSI;
                    index_next    = '0;
                    param_next[0] = '0;
                    param_next[1] = '0;
                end
                else if (rx_byte == vtkd_pkg::CH_UPPER_O)
                begin
                    mode_next = vtkd_pkg::MODE_ESC_O;
                end
                else
                begin
                    mode_next = vtkd_pkg::MODE_RAW;
                end
            end
            vtkd_pkg::MODE_ESC_O:
            begin
                mode_next = vtkd_pkg::MODE_RAW;
                if (rx_byte == vtkd_pkg::CH_UPPER_F)
                begin
                    result_valid    = 1'b1;
                    result.key_kind = vtkd_pkg::KEY_END;
                end
                else if (rx_byte == vtkd_pkg::CH_UPPER_H)
                begin
                    result_valid    = 1'b1;
                    result.key_kind = vtkd_pkg::KEY_HOME;
                end
            end
            vtkd_pkg::MODE_CSI:
            begin
                priority if (is_digit)
                begin
                    if (index_open)
                    begin
                        param_next[index_reg[0]] = digit_result;
                    end
                end
                else if (rx_byte == vtkd_pkg::CH_SEMI)
                begin
                    if (index_open)
                    begin
                        index_next = index_reg + vtkd_pkg::INDEX_BITS'(1);
                    end
                end
                else if (rx_byte == vtkd_pkg::CH_QUERY)
                begin
                    mode_next = vtkd_pkg::MODE_CSI;
                end
                else
                begin
                    mode_next = vtkd_pkg::MODE_RAW;
                    unique case (rx_byte)
                        vtkd_pkg::CH_UPPER_A:
                        begin
                            result_valid    = 1'b1;
                            result.key_kind = vtkd_pkg::KEY_UP;
                        end
                        vtkd_pkg::CH_UPPER_B:
                        begin
                            result_valid    = 1'b1;
                            result.key_kind = vtkd_pkg::KEY_DOWN;
                        end
                        vtkd_pkg::CH_UPPER_C:
                        begin
                            result_valid    = 1'b1;
                            result.key_kind = vtkd_pkg::KEY_RIGHT;
                        end
                        vtkd_pkg::CH_UPPER_D:
                        begin
                            result_valid    = 1'b1;
                            result.key_kind = vtkd_pkg::KEY_LEFT;
                        end
                        vtkd_pkg::CH_UPPER_R:
                        begin
                            result_valid        = 1'b1;
                            result.key_kind     = vtkd_pkg::KEY_CURSOR_REPORT;
                            result.first_param  = param_reg[0];
                            result.second_param = param_reg[1];
                        end
                        vtkd_pkg::CH_LOWER_C:
                        begin
                            result_valid        = 1'b1;
                            result.key_kind     = vtkd_pkg::KEY_TERM_TYPE;
                            result.first_param  = param_reg[0];
                            result.second_param = param_reg[1];
                        end
                        vtkd_pkg::CH_TILDE:
                        begin
                            // A separator seen at all marks a modifier.
                            result.ctrl_flag = (index_reg != '0);
                            result_valid     = 1'b1;
                            unique case (param_reg[0])
                                vtkd_pkg::PARAM_BITS'(1): result.key_kind = vtkd_pkg::KEY_HOME;
                                vtkd_pkg::PARAM_BITS'(2): result.key_kind = vtkd_pkg::KEY_INSERT;
                                vtkd_pkg::PARAM_BITS'(3): result.key_kind = vtkd_pkg::KEY_DELETE;
                                vtkd_pkg::PARAM_BITS'(4): result.key_kind = vtkd_pkg::KEY_END;
                                vtkd_pkg::PARAM_BITS'(5): result.key_kind = vtkd_pkg::KEY_PGUP;
                                vtkd_pkg::PARAM_BITS'(6): result.key_kind = vtkd_pkg::KEY_PGDN;
                                default:
                                begin
                                    result_valid     = 1'b0;
                                    result.ctrl_flag = 1'b0;
                                end
                            endcase
                        end
                        default:
                        begin
                            result_valid = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                mode_next = vtkd_pkg::MODE_RAW;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= vtkd_pkg::MODE_RAW;
            index_reg    <= '0;
            param_reg[0] <= '0;
            param_reg[1] <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            index_reg    <= index_next;
            param_reg[0] <= param_next[0];
            param_reg[1] <= param_next[1];
        end
    end

endmodule

// ===== src/vt100_key_sequence_decoder_top.sv =====
// ----------------------------------------------------------------------------
// vt100_key_sequence_decoder_top
// VT100 / ANSI key-sequence decoder with valid/ready byte input and key output.
// ----------------------------------------------------------------------------
// The decoder takes one terminal byte per cycle unless the output holds it off,
// and delivers at most one key result per byte. A byte lands in the input
// register. While the output register can take a result, the byte is decoded
// against the escape state in a single combinational pass, and the result is
// captured in the output register, from which it can be taken. The escape state
// updates in that same cycle. While the output is taken every cycle, a new byte
// is accepted every cycle. While a result waits on the output, one more byte is
// taken into the input register, and then the input stalls until the waiting
// result is taken.
module vt100_key_sequence_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  key_kind,
    output logic [7:0]  char_value,
    output logic        ctrl_flag,
    output logic [15:0] first_param,
    output logic [15:0] second_param
);

    logic              in_valid_reg, in_valid_next;
    vtkd_pkg::byte_t   in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    vtkd_pkg::result_t out_data_reg;

    logic              advance;
    logic              res_valid;
    vtkd_pkg::result_t res;

    // The decode stage moves whenever it holds a byte and the output register can take a result.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    vtkd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .rx_byte      (in_byte_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_kind     = out_data_reg.key_kind;
    assign char_value   = out_data_reg.char_value;
    assign ctrl_flag    = out_data_reg.ctrl_flag;
    assign first_param  = out_data_reg.first_param;
    assign second_param = out_data_reg.second_param;

endmodule

// ===== src/vtkd_checker.sv =====
// ----------------------------------------------------------------------------
// vtkd_checker
// Port-level checks on the key decoder's result channel.
// ----------------------------------------------------------------------------
module vtkd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  key_kind,
    input logic [7:0]  char_value,
    input logic        ctrl_flag,
    input logic [15:0] first_param,
    input logic [15:0] second_param
);

    // A stalled result keeps its key and parameters.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_kind)
            && $stable(first_param) && $stable(second_param))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_kind <= vtkd_pkg::KEY_TERM_TYPE)
        else $error("key kind out of range");

    // Only plain characters carry a character byte.
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_kind != vtkd_pkg::KEY_CHAR |-> char_value == 8'd0)
        else $error("character byte on a non-character key");

    // Parameters are reported only by the two report kinds.
    a_param_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_kind != vtkd_pkg::KEY_CURSOR_REPORT
            && key_kind != vtkd_pkg::KEY_TERM_TYPE
        |-> first_param == 16'd0 && second_param == 16'd0)
        else $error("parameters on a key without report");

    // The modifier flag comes only from a tilde key.
    a_ctrl_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ctrl_flag
        |-> key_kind == vtkd_pkg::KEY_HOME || key_kind == vtkd_pkg::KEY_INSERT
            || key_kind == vtkd_pkg::KEY_DELETE || key_kind == vtkd_pkg::KEY_END
            || key_kind == vtkd_pkg::KEY_PGUP || key_kind == vtkd_pkg::KEY_PGDN)
        else $error("modifier flag on a non-tilde key");

endmodule

bind vt100_key_sequence_decoder_top vtkd_checker u_vtkd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_kind     (key_kind),
    .char_value   (char_value),
    .ctrl_flag    (ctrl_flag),
    .first_param  (first_param),
    .second_param (second_param)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the VT100 key-sequence decoder. Terminal bytes are
// pushed through the valid/ready input while a behavioral decoder in the bench
// tracks the escape state and queues the key each byte should produce. Every
// key transfer on the output is compared field by field with the oldest
// queued key. Directed sequences come first, then random escape traffic under
// changing idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  key_kind;
    logic [7:0]  char_value;
    logic        ctrl_flag;
    logic [15:0] first_param;
    logic [15:0] second_param;

    // Behavioral copy of the decoder state.
    vtkd_pkg::mode_t  esc_mode;
    vtkd_pkg::index_t param_pos;
    vtkd_pkg::param_t params [vtkd_pkg::PARAM_COUNT];

    vtkd_pkg::result_t expected_keys [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_off_cycles;
    int bytes_sent;
    int keys_checked;
    int mismatches;
    int kind_count [16];

    vt100_key_sequence_decoder_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_kind     (key_kind),
        .char_value   (char_value),
        .ctrl_flag    (ctrl_flag),
        .first_param  (first_param),
        .second_param (second_param)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Advances the escape state by one byte; returns 1 when a key comes out.
    function automatic bit decode_byte(input vtkd_pkg::byte_t b,
                                       output vtkd_pkg::result_t key);
        int unsigned acc;
        key = '0;
        case (esc_mode)
            vtkd_pkg::MODE_RAW:
            begin
                if (b != vtkd_pkg::CH_ESC)
                begin
                    key.key_kind   = vtkd_pkg::KEY_CHAR;
                    key.char_value = b;
                    return 1'b1;
                end
                esc_mode = vtkd_pkg::MODE_ESC;
                return 1'b0;
            end
            vtkd_pkg::MODE_ESC:
            begin
                if (b == vtkd_pkg::CH_LBRACK)
                begin
                    esc_mode  = vtkd_pkg::MODE_CSI;
                    param_pos = '0;
                    params[0] = '0;
                    params[1] = '0;
                end
                else if (b == vtkd_pkg::CH_UPPER_O)
                    esc_mode = vtkd_pkg::MODE_ESC_O;
                else
                    esc_mode = vtkd_pkg::MODE_RAW;
                return 1'b0;
            end
            vtkd_pkg::MODE_ESC_O:
            begin
                esc_mode = vtkd_pkg::MODE_RAW;
                if (b == vtkd_pkg::CH_UPPER_F)
                begin
                    key.key_kind = vtkd_pkg::KEY_END;
                    return 1'b1;
                end
                if (b == vtkd_pkg::CH_UPPER_H)
                begin
                    key.key_kind = vtkd_pkg::KEY_HOME;
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                if (b >= vtkd_pkg::CH_ZERO && b <= vtkd_pkg::CH_NINE)
                begin
                    // Digits past the last parameter are dropped.
                    if (param_pos < vtkd_pkg::PARAM_COUNT)
                    begin
                        acc = int'(params[param_pos]) * 10 + int'(b - vtkd_pkg::CH_ZERO);
                        params[param_pos] = (acc > vtkd_pkg::PARAM_MAX)
                                          ? vtkd_pkg::PARAM_MAX
                                          : vtkd_pkg::param_t'(acc);
                    end
                    return 1'b0;
                end
                if (b == vtkd_pkg::CH_SEMI)
                begin
                    if (param_pos < vtkd_pkg::PARAM_COUNT)
                        param_pos++;
                    return 1'b0;
                end
                if (b == vtkd_pkg::CH_QUERY)
                    return 1'b0;
                esc_mode = vtkd_pkg::MODE_RAW;
                case (b)
                    vtkd_pkg::CH_UPPER_A: key.key_kind = vtkd_pkg::KEY_UP;
                    vtkd_pkg::CH_UPPER_B: key.key_kind = vtkd_pkg::KEY_DOWN;
                    vtkd_pkg::CH_UPPER_C: key.key_kind = vtkd_pkg::KEY_RIGHT;
                    vtkd_pkg::CH_UPPER_D: key.key_kind = vtkd_pkg::KEY_LEFT;
                    vtkd_pkg::CH_UPPER_R, vtkd_pkg::CH_LOWER_C:
                    begin
                        key.key_kind     = (b == vtkd_pkg::CH_UPPER_R)
                                         ? vtkd_pkg::KEY_CURSOR_REPORT
                                         : vtkd_pkg::KEY_TERM_TYPE;
                        key.first_param  = params[0];
                        key.second_param = params[1];
                    end
                    vtkd_pkg::CH_TILDE:
                    begin
                        key.ctrl_flag = (param_pos != 0);
                        case (params[0])
                            16'd1:   key.key_kind = vtkd_pkg::KEY_HOME;
                            16'd2:   key.key_kind = vtkd_pkg::KEY_INSERT;
                            16'd3:   key.key_kind = vtkd_pkg::KEY_DELETE;
                            16'd4:   key.key_kind = vtkd_pkg::KEY_END;
                            16'd5:   key.key_kind = vtkd_pkg::KEY_PGUP;
                            16'd6:   key.key_kind = vtkd_pkg::KEY_PGDN;
                            default: return 1'b0;
                        endcase
                    end
                    default: return 1'b0;
                endcase
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_byte(input vtkd_pkg::byte_t b);
        vtkd_pkg::result_t key;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        // Ready is stable at the falling edge; the transfer is the next rising edge.
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        if (decode_byte(b, key))
            expected_keys.push_back(key);
        bytes_sent++;
    endtask

    task automatic send_bytes(input vtkd_pkg::byte_t seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic send_random_sequence();
        vtkd_pkg::byte_t seq [$];
        int              pick;
        int              nparams;
        int              ndigits;
        pick = $urandom_range(99);
        if (pick < 20)
            seq.push_back(vtkd_pkg::byte_t'($urandom_range(255)));
        else if (pick < 30)
        begin
            seq = {vtkd_pkg::CH_ESC, vtkd_pkg::CH_UPPER_O};
            case ($urandom_range(2))
                0:       seq.push_back(vtkd_pkg::CH_UPPER_F);
                1:       seq.push_back(vtkd_pkg::CH_UPPER_H);
                default: seq.push_back(vtkd_pkg::byte_t'($urandom_range(255)));
            endcase
        end
        else if (pick < 36)
        begin
            seq.push_back(vtkd_pkg::CH_ESC);
            seq.push_back($urandom_range(1) ? vtkd_pkg::CH_ESC
                                            : vtkd_pkg::byte_t'($urandom_range(255)));
        end
        else if (pick < 56)
        begin
            // Editing keys: mostly valid codes, with or without a modifier.
            seq = {vtkd_pkg::CH_ESC, vtkd_pkg::CH_LBRACK,
                   vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + $urandom_range(7))};
            if ($urandom_range(2) == 0)
            begin
                seq.push_back(vtkd_pkg::CH_SEMI);
                seq.push_back(vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + $urandom_range(9)));
            end
            seq.push_back(vtkd_pkg::CH_TILDE);
        end
        else
        begin
            seq = {vtkd_pkg::CH_ESC, vtkd_pkg::CH_LBRACK};
            if ($urandom_range(9) == 0)
                seq.push_back(vtkd_pkg::CH_QUERY);
            nparams = $urandom_range(3);
            for (int i = 0; i < nparams; i++)
            begin
                if (i > 0)
                    seq.push_back(vtkd_pkg::CH_SEMI);
                ndigits = ($urandom_range(7) == 0) ? $urandom_range(4, 7) : $urandom_range(2);
                for (int j = 0; j < ndigits; j++)
                    seq.push_back(vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + $urandom_range(9)));
            end
            case ($urandom_range(9))
                0:       seq.push_back(vtkd_pkg::CH_UPPER_A);
                1:       seq.push_back(vtkd_pkg::CH_UPPER_B);
                2:       seq.push_back(vtkd_pkg::CH_UPPER_C);
                3:       seq.push_back(vtkd_pkg::CH_UPPER_D);
                4, 5:    seq.push_back(vtkd_pkg::CH_UPPER_R);
                6, 7:    seq.push_back(vtkd_pkg::CH_LOWER_C);
                8:       seq.push_back(vtkd_pkg::CH_TILDE);
                default: seq.push_back(vtkd_pkg::byte_t'($urandom_range(255)));
            endcase
        end
        send_bytes(seq);
    endtask

    task automatic test_directed();
        send_bytes({8'h00, 8'hFF});
        send_bytes({vtkd_pkg::CH_ESC, vtkd_pkg::CH_LBRACK, vtkd_pkg::CH_UPPER_A});
        // Delete with a modifier parameter.
        send_bytes({vtkd_pkg::CH_ESC, vtkd_pkg::CH_LBRACK,
                    vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + 8'd3), vtkd_pkg::CH_SEMI,
                    vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + 8'd5), vtkd_pkg::CH_TILDE});
        // Query mark, a saturating parameter and a dropped third parameter.
        send_bytes({vtkd_pkg::CH_ESC, vtkd_pkg::CH_LBRACK, vtkd_pkg::CH_QUERY,
                    vtkd_pkg::CH_NINE, vtkd_pkg::CH_NINE, vtkd_pkg::CH_NINE,
                    vtkd_pkg::CH_NINE, vtkd_pkg::CH_NINE, vtkd_pkg::CH_SEMI,
                    vtkd_pkg::CH_SEMI, vtkd_pkg::byte_t'(vtkd_pkg::CH_ZERO + 8'd8),
                    vtkd_pkg::CH_LOWER_C});
        send_bytes({vtkd_pkg::CH_ESC, 8'h78});
    endtask

    task automatic test_random_traffic(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_sequence();
    endtask

    // The receiver stops for a long stretch while bytes keep coming, so the
    // decoder fills and has to stall its input.
    task automatic test_output_hold();
        hold_off_cycles = HOLD_CYCLES;
        repeat (40) send_random_sequence();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_keys
        vtkd_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_keys.size() == 0)
            begin
                $display("%0t: unexpected key, expected none, actual kind %0d char %0d",
                         $time, key_kind, char_value);
                mismatches++;
            end
            else
            begin
                want = expected_keys.pop_front();
                keys_checked++;
                kind_count[key_kind]++;
                check_field("key_kind", 16'(want.key_kind), 16'(key_kind));
                check_field("char_value", 16'(want.char_value), 16'(char_value));
                check_field("ctrl_flag", 16'(want.ctrl_flag), 16'(ctrl_flag));
                check_field("first_param", want.first_param, first_param);
                check_field("second_param", want.second_param, second_param);
            end
        end
    end

    initial
    begin
        int kinds_seen;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        rx_byte         = '0;
        tx_idle_pct     = 7;
        rx_stall_pct    = 68;
        hold_off_cycles = 0;
        bytes_sent      = 0;
        keys_checked    = 0;
        mismatches      = 0;
        kinds_seen      = 0;
        esc_mode        = vtkd_pkg::MODE_RAW;
        param_pos       = '0;
        params[0]       = '0;
        params[1]       = '0;
        foreach (kind_count[i])
            kind_count[i] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_traffic(120);
        tx_idle_pct  = 68;
        rx_stall_pct = 7;
        test_random_traffic(120);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_output_hold();
        test_random_traffic(116);
        in_valid <= 1'b0;

        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        foreach (kind_count[i])
            if (kind_count[i] > 0)
                kinds_seen++;
        $display("Run covered %0d bytes in and %0d key transfers checked,", bytes_sent,
                 keys_checked);
        $display("with %0d of 13 key kinds seen and one long output hold-off.", kinds_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
